@@ sv/utf8_stream_decoder_top_assert.svh @@
// assertion macros for the utf8 stream decoder
// used by utf8_stream_decoder_top; no other dependencies
`ifndef UTF8_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_STREAM_DECODER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition must hold at every edge out of reset
`define U8SD_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("utf8 stream decoder check failed");
// consequent must hold in the same cycle as the antecedent
`define U8SD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("utf8 stream decoder check failed");
// consequent must hold in the cycle after the antecedent
`define U8SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("utf8 stream decoder check failed");
`else
`define U8SD_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define U8SD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define U8SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/utf8sd_pkg.sv @@
// types and constants for the utf8 stream decoder
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
package utf8sd_pkg;

	localparam int unsigned CP_W = 21;

	// byte class masks and patterns
	localparam logic [7:0] MASK_CONT  = 8'hC0;
	localparam logic [7:0] PAT_CONT   = 8'h80;
	localparam logic [7:0] MASK_LEAD2 = 8'hE0;
	localparam logic [7:0] PAT_LEAD2  = 8'hC0;
	localparam logic [7:0] MASK_LEAD3 = 8'hF0;
	localparam logic [7:0] PAT_LEAD3  = 8'hE0;
	localparam logic [7:0] MASK_LEAD4 = 8'hF8;
	localparam logic [7:0] PAT_LEAD4  = 8'hF0;
	localparam logic [7:0] BITS_CONT  = 8'h3F;
	localparam logic [7:0] BITS_LEAD2 = 8'h1F;
	localparam logic [7:0] BITS_LEAD3 = 8'h0F;
	localparam logic [7:0] BITS_LEAD4 = 8'h07;

	// input item: one byte of text
	typedef struct packed {
		logic [7:0] byte_in;
		logic       last_byte;
	} in_item_t;

	// result item: one code point
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            bad;
		logic            last_out;
	} out_item_t;

	// results caused by one byte: pre bad zeros, optional main result, then
	// bad zeros up to total
	typedef struct packed {
		logic [1:0]      pre;
		logic            has_main;
		logic [CP_W-1:0] main_cp;
		logic            main_bad;
		logic [2:0]      total;
		logic            last;
	} burst_t;

endpackage

@@ sv/utf8sd_decode.sv @@
// byte decoder: sequence state registers and the per-byte result burst
// depends on utf8sd_pkg
`timescale 1ns / 1ps
module utf8sd_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  utf8sd_pkg::in_item_t item,
	input  logic                 advance,
	output utf8sd_pkg::burst_t   burst
);

	logic [utf8sd_pkg::CP_W-1:0] partial_q, partial_d;
	logic [1:0]                  need_q, need_d;
	logic [1:0]                  taken_q, taken_d;

	// decode one byte against the pending sequence
	always_comb begin
		logic [7:0] b;
		logic       cont;
		logic [1:0] post;
		b         = item.byte_in;
		cont      = (b & utf8sd_pkg::MASK_CONT) == utf8sd_pkg::PAT_CONT;
		partial_d = partial_q;
		need_d    = need_q;
		taken_d   = taken_q;
		post      = 2'd0;
		burst     = '0;
		if (need_q != 2'd0 && cont) begin
			// continuation gathers six more bits
			partial_d = {partial_q[utf8sd_pkg::CP_W-7:0], b[5:0]};
			need_d    = need_q - 2'd1;
			if (need_d == 2'd0) begin
				burst.has_main = 1'b1;
				burst.main_cp  = partial_d;
				partial_d      = '0;
				taken_d        = 2'd0;
			end else begin
				taken_d = taken_q + 2'd1;
			end
		end else begin
			// broken sequence gives a bad zero for the lead and each continuation
			if (need_q != 2'd0) begin
				burst.pre = taken_q + 2'd1;
			end
			partial_d = '0;
			need_d    = 2'd0;
			taken_d   = 2'd0;
			if (b[7] == 1'b0) begin
				burst.has_main = 1'b1;
				burst.main_cp  = utf8sd_pkg::CP_W'(b);
			end else if ((b & utf8sd_pkg::MASK_LEAD2) == utf8sd_pkg::PAT_LEAD2) begin
				partial_d = utf8sd_pkg::CP_W'(b & utf8sd_pkg::BITS_LEAD2);
				need_d    = 2'd1;
			end else if ((b & utf8sd_pkg::MASK_LEAD3) == utf8sd_pkg::PAT_LEAD3) begin
				partial_d = utf8sd_pkg::CP_W'(b & utf8sd_pkg::BITS_LEAD3);
				need_d    = 2'd2;
			end else if ((b & utf8sd_pkg::MASK_LEAD4) == utf8sd_pkg::PAT_LEAD4) begin
				partial_d = utf8sd_pkg::CP_W'(b & utf8sd_pkg::BITS_LEAD4);
				need_d    = 2'd3;
			end else begin
				// stray continuation or invalid lead
				burst.has_main = 1'b1;
				burst.main_bad = 1'b1;
			end
		end
		// last byte flushes whatever is still pending
		if (item.last_byte) begin
			if (need_d != 2'd0) begin
				post = taken_d + 2'd1;
			end
			partial_d = '0;
			need_d    = 2'd0;
			taken_d   = 2'd0;
		end
		burst.last  = item.last_byte;
		burst.total = 3'(burst.pre) + 3'(burst.has_main) + 3'(post);
	end

	// sequence state advances when the burst moves to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			need_q    <= 2'd0;
			taken_q   <= 2'd0;
		end else if (advance) begin
			partial_q <= partial_d;
			need_q    <= need_d;
			taken_q   <= taken_d;
		end
	end

endmodule

@@ sv/utf8sd_emit.sv @@
// result stage: holds one burst and hands out its results one per cycle while cp_ready is high
// depends on utf8sd_pkg
`timescale 1ns / 1ps
module utf8sd_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  utf8sd_pkg::burst_t    burst,
	output logic                  free,
	output logic                  cp_valid,
	input  logic                  cp_ready,
	output utf8sd_pkg::out_item_t cp_item
);

	utf8sd_pkg::burst_t burst_s2;
	logic [2:0]         rem_q;
	logic [1:0]         idx_q;
	logic               is_main;

	assign cp_valid = rem_q != 3'd0;
	assign free     = (rem_q == 3'd0) || (rem_q == 3'd1 && cp_ready);

	// select the result at the current position of the burst
	always_comb begin
		is_main            = burst_s2.has_main && (idx_q == burst_s2.pre);
		cp_item.code_point = is_main ? burst_s2.main_cp : '0;
		cp_item.bad        = is_main ? burst_s2.main_bad : 1'b1;
		cp_item.last_out   = burst_s2.last && (rem_q == 3'd1);
	end

	// burst payload
	always_ff @(posedge clk) begin
		if (load) begin
			burst_s2 <= burst;
		end
	end

	// position within the burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			rem_q <= burst.total;
			idx_q <= 2'd0;
		end else if (cp_valid && cp_ready) begin
			rem_q <= rem_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

@@ sv/utf8_stream_decoder_top.sv @@
// utf8 stream decoder: byte input register, decoder and result stage
// depends on utf8sd_pkg, utf8sd_decode, utf8sd_emit, utf8_stream_decoder_top_assert.svh
//
// Usage:
//  Byte channel (byte_valid/byte_ready/byte_item) takes one byte of UTF-8
//  text per item; last_byte marks the end of a string and flushes any
//  unfinished sequence as bad zeros.
//  Code point channel (cp_valid/cp_ready/cp_item) gives decoded code points;
//  malformed bytes give code point 0 with bad set. last_out marks the final
//  result caused by the final byte.
//  A byte passes the input register and then the result register, and its
//  first result is offered from the result register.
//  Throughput: one byte per cycle while each byte gives at most one result and the receiver does not stall.
//  A byte that gives n results holds the result register until all are taken
//  (at most four), and the byte channel stalls behind it.
//  Bytes inside a sequence give no result and pass at one per cycle unless stalled.
//  Reset clears the sequence state and empties both registers.
//  When the receiver stalls, the current result holds and one more byte
//  is buffered in the input register before byte_ready drops.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_top_assert.svh"
module utf8_stream_decoder_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  utf8sd_pkg::in_item_t  byte_item,
	output logic                  cp_valid,
	input  logic                  cp_ready,
	output utf8sd_pkg::out_item_t cp_item
);

	utf8sd_pkg::in_item_t item_s1;
	logic                 valid_s1;
	utf8sd_pkg::burst_t   burst;
	logic                 free;
	logic                 load;

	assign load       = valid_s1 && free;
	assign byte_ready = !valid_s1 || load;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
	end

	// decoder with sequence state
	utf8sd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (load),
		.burst   (burst)
	);

	// result stage
	utf8sd_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.burst    (burst),
		.free     (free),
		.cp_valid (cp_valid),
		.cp_ready (cp_ready),
		.cp_item  (cp_item)
	);

	// checks
	`U8SD_ASSERT_IMPLIES(a_last_has_result, clk, arst_n, load && burst.last, burst.total != 3'd0)
	`U8SD_ASSERT_ALWAYS(a_burst_bounded, clk, arst_n, !load || burst.total <= 3'd4)
	`U8SD_ASSERT_IMPLIES(a_stall_cause, clk, arst_n, !byte_ready, valid_s1 && cp_valid)
	`U8SD_ASSERT_NEXT(a_load_shows, clk, arst_n, load && burst.total != 3'd0, cp_valid)

endmodule

@@ bench/testbench.sv @@
// testbench for utf8_stream_decoder_top: directed byte table, then random utf-8 strings
// depends on utf8sd_pkg and the decoder rtl; results are checked against a local decoder model
`timescale 1ns / 1ps
module testbench;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int          RAND_ITEMS    = 480;
	localparam int          HOLD_CYCLES   = 80;
	localparam int          TAIL_CYCLES   = 8;
	localparam int          DIR_ROWS      = 25;

	// directed row: byte, last, typed, count, code point, bad
	// typed rows carry their results here; the others use the decoder model
	typedef struct packed {
		logic [7:0]                  b;
		logic                        last;
		logic                        typed;
		logic [2:0]                  n;
		logic [utf8sd_pkg::CP_W-1:0] cp;
		logic                        bad;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
		// single bytes at the extremes, stray continuations, invalid leads
		'{8'h00, 1'b0, 1'b1, 3'd1, 21'h000000, 1'b0},
		'{8'h7F, 1'b0, 1'b1, 3'd1, 21'h00007F, 1'b0},
		'{8'h80, 1'b0, 1'b1, 3'd1, 21'h000000, 1'b1},
		'{8'hBF, 1'b0, 1'b1, 3'd1, 21'h000000, 1'b1},
		'{8'hF8, 1'b0, 1'b1, 3'd1, 21'h000000, 1'b1},
		'{8'hFF, 1'b1, 1'b1, 3'd1, 21'h000000, 1'b1},
		// two byte sequence
		'{8'hC2, 1'b0, 1'b1, 3'd0, 21'h000000, 1'b0},
		'{8'hA9, 1'b0, 1'b1, 3'd1, 21'h0000A9, 1'b0},
		// three byte sequence
		'{8'hE2, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
		'{8'h82, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
		'{8'hAC, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
		// four byte sequence at the top of the range
		'{8'hF7, 1'b0, 1'b1, 3'd0, 21'h000000, 1'b0},
		'{8'hBF, 1'b0, 1'b1, 3'd0, 21'h000000, 1'b0},
		'{8'hBF, 1'b0, 1'b1, 3'd0, 21'h000000, 1'b0},
		'{8'hBF, 1'b0, 1'b1, 3'd1, 21'h1FFFFF, 1'b0},
		// four byte sequence with all payload bits clear
		'{8'hF0, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
		'{8'h80, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
		'{8'h80, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
		'{8'h80, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
		// sequence broken by a plain ascii byte
		'{8'hE2, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
		'{8'h82, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
		'{8'h41, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
		// unfinished sequence flushed by the final byte
		'{8'hF0, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
		'{8'h90, 1'b1, 1'b0, 3'd0, 21'h000000, 1'b0},
		'{8'hC3, 1'b1, 1'b1, 3'd1, 21'h000000, 1'b1}
	};

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  byte_valid = 1'b0;
	logic                  byte_ready;
	utf8sd_pkg::in_item_t  byte_item  = '0;
	logic                  cp_valid;
	logic                  cp_ready   = 1'b0;
	utf8sd_pkg::out_item_t cp_item;

	// decoder model state
	logic [utf8sd_pkg::CP_W-1:0] cp_acc    = '0;
	logic [1:0]                  cont_left = '0;
	logic [1:0]                  cont_seen = '0;

	utf8sd_pkg::out_item_t pred_q[$];
	utf8sd_pkg::out_item_t cp_expect_q[$];
	utf8sd_pkg::in_item_t  text_q[$];
	int                    fails  = 0;
	int unsigned           cycles = 0;
	bit                    calm   = 1'b0;
	bit                    rx_hold_go   = 1'b0;
	bit                    rx_hold_done = 1'b0;

	utf8_stream_decoder_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item (byte_item),
		.cp_valid  (cp_valid),
		.cp_ready  (cp_ready),
		.cp_item   (cp_item)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function void push_cp(input logic [utf8sd_pkg::CP_W-1:0] cp, input logic bad);
		utf8sd_pkg::out_item_t r;
		r.code_point = cp;
		r.bad        = bad;
		r.last_out   = 1'b0;
		pred_q.push_back(r);
	endfunction

	// pending sequence gives one bad zero for the lead and each continuation taken
	function void flush_seq();
		int k;
		if (cont_left != 2'd0) begin
			for (k = 0; k <= cont_seen; k++)
				push_cp('0, 1'b1);
		end
		cp_acc    = '0;
		cont_left = '0;
		cont_seen = '0;
	endfunction

	// code points caused by one byte, left in pred_q
	function void decode_byte(input utf8sd_pkg::in_item_t it);
		utf8sd_pkg::out_item_t tail;
		pred_q.delete();
		if (cont_left != 2'd0 &&
				(it.byte_in & utf8sd_pkg::MASK_CONT) == utf8sd_pkg::PAT_CONT) begin
			cp_acc    = {cp_acc[utf8sd_pkg::CP_W-7:0], it.byte_in[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0) begin
				push_cp(cp_acc, 1'b0);
				cp_acc    = '0;
				cont_seen = '0;
			end else begin
				cont_seen = cont_seen + 2'd1;
			end
		end else begin
			flush_seq();
			if (it.byte_in[7] == 1'b0) begin
				push_cp({13'b0, it.byte_in}, 1'b0);
			end else if ((it.byte_in & utf8sd_pkg::MASK_LEAD2) == utf8sd_pkg::PAT_LEAD2) begin
				cp_acc    = {13'b0, it.byte_in & utf8sd_pkg::BITS_LEAD2};
				cont_left = 2'd1;
			end else if ((it.byte_in & utf8sd_pkg::MASK_LEAD3) == utf8sd_pkg::PAT_LEAD3) begin
				cp_acc    = {13'b0, it.byte_in & utf8sd_pkg::BITS_LEAD3};
				cont_left = 2'd2;
			end else if ((it.byte_in & utf8sd_pkg::MASK_LEAD4) == utf8sd_pkg::PAT_LEAD4) begin
				cp_acc    = {13'b0, it.byte_in & utf8sd_pkg::BITS_LEAD4};
				cont_left = 2'd3;
			end else begin
				push_cp('0, 1'b1);
			end
		end
		// final byte flushes and marks the last result
		if (it.last_byte) begin
			flush_seq();
			if (pred_q.size() != 0) begin
				tail = pred_q.pop_back();
				tail.last_out = 1'b1;
				pred_q.push_back(tail);
			end
		end
	endfunction

	// offer one byte, at random with byte_valid dropped ahead of it, and decode it once accepted
	task automatic offer_byte(input utf8sd_pkg::in_item_t it);
		if (!calm && $urandom_range(99) < 7) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_item  <= it;
		byte_valid <= 1'b1;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		decode_byte(it);
	endtask

	// stop offering until every expected code point has come
	task automatic wait_drained();
		byte_valid <= 1'b0;
		do @(posedge clk); while (cp_expect_q.size() != 0);
	endtask

	// receiver: random stalls, plus one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_go && !rx_hold_done) begin
				cp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold_done = 1'b1;
			end else begin
				cp_ready <= calm || ($urandom_range(99) >= 7);
			end
		end
	end

	// code point checker
	always @(posedge clk) begin : cp_check
		utf8sd_pkg::out_item_t want;
		if (arst_n && cp_valid && cp_ready) begin
			if (cp_expect_q.size() == 0) begin
				$display("%0t: unexpected code point, expected none, got cp=%h bad=%b last=%b",
					$time, cp_item.code_point, cp_item.bad, cp_item.last_out);
				fails++;
			end else begin
				want = cp_expect_q.pop_front();
				if (cp_item.code_point !== want.code_point || cp_item.bad !== want.bad ||
						cp_item.last_out !== want.last_out) begin
					$display({"%0t: mismatch, expected cp=%h bad=%b last=%b, ",
						"got cp=%h bad=%b last=%b"},
						$time, want.code_point, want.bad, want.last_out,
						cp_item.code_point, cp_item.bad, cp_item.last_out);
					fails++;
				end
			end
		end
	end

	// stimulus
	initial begin : stim
		dir_row_t             row;
		utf8sd_pkg::in_item_t item;
		int                   rand_sent;
		int                   n_chars;
		int                   len;
		int                   ncont;
		int                   r;
		int                   i;
		int                   k;

		rand_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TAB[i];
			item.byte_in   = row.b;
			item.last_byte = row.last;
			offer_byte(item);
			if (row.typed) begin
				pred_q.delete();
				for (k = 0; k < row.n; k++) begin
					push_cp(row.cp, row.bad);
					if (row.last && k == row.n - 1)
						pred_q[k].last_out = 1'b1;
				end
			end
			foreach (pred_q[j]) cp_expect_q.push_back(pred_q[j]);
		end

		// random strings: mostly well formed, some noise and truncated sequences
		while (rand_sent < RAND_ITEMS) begin
			text_q.delete();
			n_chars = $urandom_range(1, 8);
			for (i = 0; i < n_chars; i++) begin
				r = $urandom_range(99);
				item.last_byte = 1'b0;
				if (r < 8) begin
					item.byte_in = 8'($urandom_range(255));
					text_q.push_back(item);
				end else begin
					len = $urandom_range(1, 4);
					case (len)
						1: item.byte_in = {1'b0, 7'($urandom)};
						2: item.byte_in = {3'b110, 5'($urandom)};
						3: item.byte_in = {4'b1110, 4'($urandom)};
						default: item.byte_in = {5'b11110, 3'($urandom)};
					endcase
					text_q.push_back(item);
					ncont = len - 1;
					if (r < 18 && ncont > 0)
						ncont = $urandom_range(0, ncont - 1);
					for (k = 0; k < ncont; k++) begin
						item.byte_in = {2'b10, 6'($urandom)};
						text_q.push_back(item);
					end
				end
			end
			text_q[text_q.size() - 1].last_byte = 1'b1;

			foreach (text_q[i]) begin
				offer_byte(text_q[i]);
				foreach (pred_q[j]) cp_expect_q.push_back(pred_q[j]);
				rand_sent++;
				// phases: long receiver hold, calm stretch, sender pause
				if (rand_sent == 120)
					rx_hold_go = 1'b1;
				if (rand_sent == 200)
					calm = 1'b1;
				if (rand_sent == 290)
					calm = 1'b0;
				if (rand_sent == 340)
					wait_drained();
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/utf8sd_pkg.sv
sv/utf8sd_decode.sv
sv/utf8sd_emit.sv
sv/utf8_stream_decoder_top.sv
bench/testbench.sv
